FILE: src/ugb_pkg.sv
// ugb_pkg: types and fixed sizes of the uniform grid broadphase
// used by the item interfaces and by uniform_grid_broadphase
`default_nettype none

package ugb_pkg;

  // grid and storage sizes
  localparam int unsigned MAX_ROWS       = 16;
  localparam int unsigned MAX_COLS       = 16;
  localparam int unsigned CELL_CAP       = 8;
  localparam int unsigned MAX_NEIGHBOURS = 64;
  localparam int unsigned EXTENT_CELLS   = 6;
  localparam int unsigned QUERY_SPAN     = 8;

  localparam int unsigned NUM_CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned NUM_ENTS  = NUM_CELLS * CELL_CAP;

  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  localparam int unsigned CELL_W = $clog2(NUM_CELLS);
  localparam int unsigned ENT_W  = $clog2(NUM_ENTS);
  localparam int unsigned SLOT_W = $clog2(CELL_CAP);
  localparam int unsigned CNT_W  = $clog2(CELL_CAP + 1);
  localparam int unsigned NB_W   = $clog2(MAX_NEIGHBOURS + 1);

  // field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned NUM_W      = COORD_W + 1;
  localparam int unsigned CS_W       = 31;
  localparam int unsigned GRID_W     = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // cell index quotients saturate at 2**QBITS-1, far above any grid size
  localparam int unsigned QBITS = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } ugb_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_CELL_FULL = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_EMPTY     = 3'd4
  } ugb_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_CELL_SIZE = 3'd2,
    CFG_GRID_ROWS = 3'd3,
    CFG_GRID_COLS = 3'd4
  } ugb_cfg_e;

  // which bound the divider works on: bit 0 ceil side, bit 1 y axis
  typedef enum logic [1:0] {
    V_LO_X = 2'd0,
    V_HI_X = 2'd1,
    V_LO_Y = 2'd2,
    V_HI_Y = 2'd3
  } ugb_val_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DLOAD,
    S_DTEST,
    S_DITER,
    S_RANGE,
    S_CRD,
    S_CNT,
    S_ENT,
    S_FIN
  } ugb_state_e;

  typedef struct packed {
    logic             empty;
    logic             wide;
    logic [QBITS-1:0] lo;
    logic [QBITS-1:0] hi;
  } ugb_span_t;

endpackage

`default_nettype wire

FILE: src/ugb_req_if.sv
// ugb_req_if: request item channel (valid, ready, operation and box)
// depends on ugb_pkg for field widths
`default_nettype none

interface ugb_req_if import ugb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [ID_W-1:0]           entity_id;
  logic signed [COORD_W-1:0] box_min_x;
  logic signed [COORD_W-1:0] box_min_y;
  logic signed [COORD_W-1:0] box_max_x;
  logic signed [COORD_W-1:0] box_max_y;

  modport source (
    output valid, func, entity_id, box_min_x, box_min_y, box_max_x, box_max_y,
    input  ready
  );
  modport sink (
    input  valid, func, entity_id, box_min_x, box_min_y, box_max_x, box_max_y,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/ugb_rsp_if.sv
// ugb_rsp_if: result item channel (valid, ready, status and neighbour id)
// depends on ugb_pkg for field widths
`default_nettype none

interface ugb_rsp_if import ugb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                neighbour_valid;
  logic [ID_W-1:0]     neighbour_id;
  logic                last;

  modport source (output valid, status, neighbour_valid, neighbour_id, last, input ready);
  modport sink   (input valid, status, neighbour_valid, neighbour_id, last, output ready);
endinterface

`default_nettype wire

FILE: src/uniform_grid_broadphase.sv
// uniform_grid_broadphase: 2d uniform grid broadphase with insert, remove and query
// depends on ugb_pkg, ugb_req_if and ugb_rsp_if
//
// One item is worked on at a time. An item first has its box checked (insert size
// limit), then the four cell bounds floor((min-origin)/cell) and ceil((max-origin)/cell)
// come out of one shared compare-subtract divider, which only loads and tests a bound
// whose offset is negative or huge and otherwise also works out its quotient bits. The
// covered cells are then walked in row-major order against two single-port-read memories
// (per-cell count, per-slot entity id) with registered reads: an insert reads the count
// and writes each cell that is not full, a remove or a query also reads each stored entry,
// and the final result item is then sent. The accept, the size check and the range clip are states of their own.
// A query stalls its walk while the result register is still held by the sink. After
// reset the counts read as zero through per-cell valid flops, so no clearing pass runs
// and the block takes items right away. Configuration is taken at any time but must
// only change while the block is idle.
`default_nettype none

module uniform_grid_broadphase import ugb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ugb_req_if.sink               req_i,
  ugb_rsp_if.source             rsp_o
);

  // configuration registers
  logic [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [CS_W-1:0]    cell_size_q;
  logic [GRID_W-1:0]  grid_rows_q, grid_cols_q;

  ugb_state_e state_q, state_d;

  // latched item
  ugb_func_e          func_q;
  logic [ID_W-1:0]    id_q;
  logic [COORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

  // item status
  logic            big_q, flag_q, have_q, found_q;
  logic [NB_W-1:0] n_q;
  logic [ID_W-1:0] pend_q;

  // divider
  ugb_val_e         val_q;
  logic [NUM_W-1:0] rem_q;
  logic [NUM_W+2:0] dsh_q;
  logic [2:0]       bit_q;
  logic [QBITS-1:0] quo_q;
  logic [QBITS-1:0] res_q [4];
  logic [3:0]       neg_q;

  // cell walk
  logic [COL_W-1:0]  lox_q, hix_q, c_q;
  logic [ROW_W-1:0]  hiy_q, r_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] kd_q;

  // memories
  logic [CNT_W-1:0] cnt_mem [NUM_CELLS];
  logic [ID_W-1:0]  ent_mem [NUM_ENTS];
  logic [NUM_CELLS-1:0] cvalid_q;
  logic [CNT_W-1:0] cnt_rd_q;
  logic             cv_rd_q;
  logic [ID_W-1:0]  ent_rd_q;

  // result register
  logic            out_valid_q;
  ugb_status_e     out_st_q;
  logic            out_nv_q;
  logic [ID_W-1:0] out_nid_q;
  logic            out_last_q;

  // ---------------------------------------------------------------- datapath terms
  logic [CS_W-1:0]    cs_eff;
  logic [CS_W+2:0]    six_cs;
  logic [NUM_W-1:0]   dx, dy;
  logic               too_big;
  logic [COORD_W-1:0] num_src, num_org;
  logic               is_ceil;
  logic [NUM_W:0]     n_plus_d;
  logic               n_neg, n_sat, ceil_neg;
  logic               div_ge;
  logic [NUM_W-1:0]   rem_nx;
  logic [QBITS-1:0]   quo_nx;
  logic [QBITS:0]     quo_up;
  logic [QBITS-1:0]   quo_fin;
  ugb_span_t          sx, sy;
  logic               cell_last;
  logic [CELL_W-1:0]  cell_addr;
  logic [CNT_W-1:0]   cnt_cur;
  logic               ent_last, keep, need_emit, stall, rm_match;
  logic               out_free;

  // zero cell size acts as one
  assign cs_eff = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
  assign six_cs = {1'b0, cs_eff, 2'b00} + {2'b00, cs_eff, 1'b0};
  assign dx = {max_x_q[COORD_W-1], max_x_q} - {min_x_q[COORD_W-1], min_x_q};
  assign dy = {max_y_q[COORD_W-1], max_y_q} - {min_y_q[COORD_W-1], min_y_q};
  assign too_big = ($signed({{2{dx[NUM_W-1]}}, dx}) > $signed({1'b0, six_cs})) ||
                   ($signed({{2{dy[NUM_W-1]}}, dy}) > $signed({1'b0, six_cs}));

  // divider operand selection
  assign is_ceil = val_q[0];
  always_comb begin
    case (val_q)
      V_LO_X:  num_src = min_x_q;
      V_HI_X:  num_src = max_x_q;
      V_LO_Y:  num_src = min_y_q;
      default: num_src = max_y_q;
    endcase
  end
  assign num_org = val_q[1] ? origin_y_q : origin_x_q;

  // negative offset: floor clips to zero, ceil is zero or below the grid
  assign n_neg    = rem_q[NUM_W-1];
  assign n_plus_d = {rem_q[NUM_W-1], rem_q} + {3'b000, cs_eff};
  assign ceil_neg = is_ceil && (n_plus_d[NUM_W] || (n_plus_d == '0));
  assign n_sat    = {4'b0000, rem_q} >= {cs_eff, 6'b000000};

  // one quotient bit per cycle
  assign div_ge  = {3'b000, rem_q} >= dsh_q;
  assign rem_nx  = div_ge ? (rem_q - dsh_q[NUM_W-1:0]) : rem_q;
  assign quo_nx  = quo_q | (QBITS'(1) << bit_q);
  assign quo_up  = {1'b0, quo_nx} + (QBITS+1)'(is_ceil && (rem_nx != '0));
  assign quo_fin = quo_up[QBITS] ? {QBITS{1'b1}} : quo_up[QBITS-1:0];

  // clip one axis to the grid in use
  function automatic ugb_span_t span_of(input logic [QBITS-1:0] lo,
                                        input logic [QBITS-1:0] hi,
                                        input logic             neg,
                                        input logic [GRID_W-1:0] grid,
                                        input logic [GRID_W-1:0] maxv);
    logic [GRID_W-1:0] lim;
    logic [QBITS-1:0]  hic;
    ugb_span_t         s;
    lim = (grid > maxv) ? maxv : grid;
    hic = ({1'b0, hi} >= {2'b00, lim}) ? QBITS'(lim - GRID_W'(1)) : hi;
    s.empty = (lim == '0) || neg || (lo > hic);
    s.wide  = !s.empty && ((hic - lo) >= QBITS'(QUERY_SPAN));
    s.lo    = lo;
    s.hi    = hic;
    return s;
  endfunction

  assign sx = span_of(res_q[V_LO_X], res_q[V_HI_X], neg_q[V_HI_X], grid_cols_q,
                      GRID_W'(MAX_COLS));
  assign sy = span_of(res_q[V_LO_Y], res_q[V_HI_Y], neg_q[V_HI_Y], grid_rows_q,
                      GRID_W'(MAX_ROWS));

  // walk terms
  assign cell_addr = CELL_W'(r_q) * CELL_W'(MAX_COLS) + CELL_W'(c_q);
  assign cell_last = (c_q == hix_q) && (r_q == hiy_q);
  assign cnt_cur   = cv_rd_q ? cnt_rd_q : '0;
  assign ent_last  = ({1'b0, kd_q} == (cnt_q - CNT_W'(1)));
  assign out_free  = !out_valid_q || rsp_o.ready;

  assign keep      = (ent_rd_q != id_q);
  assign need_emit = (func_q == FUNC_QUERY) && keep && have_q &&
                     (n_q < NB_W'(MAX_NEIGHBOURS - 1));
  assign stall     = need_emit && !out_free;
  assign rm_match  = !found_q && (ent_rd_q == id_q);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (func_q == FUNC_NONE) state_d = S_IDLE;
        else if (func_q == FUNC_INSERT && too_big) state_d = S_FIN;
        else state_d = S_DLOAD;
      end
      S_DLOAD: state_d = S_DTEST;
      S_DTEST: begin
        if (!n_neg && !n_sat) state_d = S_DITER;
        else if (val_q == V_HI_Y) state_d = S_RANGE;
        else state_d = S_DLOAD;
      end
      S_DITER: begin
        if (bit_q == '0) begin
          state_d = (val_q == V_HI_Y) ? S_RANGE : S_DLOAD;
        end
      end
      S_RANGE: begin
        if (func_q == FUNC_QUERY && (sx.wide || sy.wide)) state_d = S_FIN;
        else if (sx.empty || sy.empty) state_d = S_FIN;
        else state_d = S_CRD;
      end
      S_CRD: state_d = S_CNT;
      S_CNT: begin
        if (func_q == FUNC_INSERT || cnt_cur == '0) begin
          state_d = cell_last ? S_FIN : S_CRD;
        end else begin
          state_d = S_ENT;
        end
      end
      S_ENT: begin
        if (!stall && ent_last) state_d = cell_last ? S_FIN : S_CRD;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  logic              cnt_re, cnt_we;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              ent_re, ent_we;
  logic [SLOT_W-1:0] ent_rslot, ent_wslot;
  logic [ID_W-1:0]   ent_wdata;
  logic              out_load;
  ugb_status_e       out_st;
  logic              out_nv;
  logic [ID_W-1:0]   out_nid;
  logic              out_last;
  logic              adv_cell, adv_slot;

  always_comb begin
    cnt_re    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_cur + CNT_W'(1);
    ent_re    = 1'b0;
    ent_rslot = '0;
    ent_we    = 1'b0;
    ent_wslot = cnt_cur[SLOT_W-1:0];
    ent_wdata = id_q;
    out_load  = 1'b0;
    out_st    = ST_OK;
    out_nv    = 1'b0;
    out_nid   = '0;
    out_last  = 1'b1;
    adv_cell  = 1'b0;
    adv_slot  = 1'b0;
    case (state_q)
      S_CRD: cnt_re = 1'b1;
      S_CNT: begin
        if (func_q == FUNC_INSERT) begin
          adv_cell = 1'b1;
          // a full cell is skipped and flagged
          if (cnt_cur < CNT_W'(CELL_CAP)) begin
            cnt_we = 1'b1;
            ent_we = 1'b1;
          end
        end else if (cnt_cur == '0) begin
          adv_cell = 1'b1;
        end else begin
          ent_re = 1'b1;
        end
      end
      S_ENT: begin
        if (func_q == FUNC_REMOVE) begin
          // entries after the match move down one slot
          ent_wslot = kd_q - SLOT_W'(1);
          ent_wdata = ent_rd_q;
          ent_we    = found_q;
          cnt_wdata = cnt_q - CNT_W'(1);
          cnt_we    = ent_last && (found_q || rm_match);
        end
        if (need_emit && out_free) begin
          out_load = 1'b1;
          out_nv   = 1'b1;
          out_nid  = pend_q;
          out_last = 1'b0;
        end
        if (!stall) begin
          if (ent_last) begin
            adv_cell = 1'b1;
          end else begin
            adv_slot  = 1'b1;
            ent_re    = 1'b1;
            ent_rslot = kd_q + SLOT_W'(1);
          end
        end
      end
      S_FIN: begin
        out_load = out_free;
        if (big_q) begin
          out_st = ST_TOO_LARGE;
        end else if (func_q == FUNC_INSERT) begin
          out_st = flag_q ? ST_CELL_FULL : ST_OK;
        end else if (func_q == FUNC_QUERY) begin
          if (!have_q) begin
            out_st = ST_EMPTY;
          end else begin
            out_st  = flag_q ? ST_TRUNCATED : ST_OK;
            out_nv  = 1'b1;
            out_nid = pend_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_st_q;
  assign rsp_o.neighbour_valid = out_nv_q;
  assign rsp_o.neighbour_id    = out_nid_q;
  assign rsp_o.last            = out_last_q;

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= CS_W'(256);
      grid_rows_q <= GRID_W'(16);
      grid_cols_q <= GRID_W'(16);
      big_q       <= 1'b0;
      flag_q      <= 1'b0;
      have_q      <= 1'b0;
      found_q     <= 1'b0;
      n_q         <= '0;
      val_q       <= V_LO_X;
      cvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X:  origin_x_q  <= cfg_data_i;
          CFG_ORIGIN_Y:  origin_y_q  <= cfg_data_i;
          CFG_CELL_SIZE: cell_size_q <= cfg_data_i[CS_W-1:0];
          CFG_GRID_ROWS: grid_rows_q <= cfg_data_i[GRID_W-1:0];
          CFG_GRID_COLS: grid_cols_q <= cfg_data_i[GRID_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          big_q   <= 1'b0;
          flag_q  <= 1'b0;
          have_q  <= 1'b0;
          n_q     <= '0;
          val_q   <= V_LO_X;
        end
        S_CHECK: begin
          if (func_q == FUNC_INSERT && too_big) big_q <= 1'b1;
        end
        S_DTEST: begin
          if (n_neg || n_sat) val_q <= ugb_val_e'(val_q + 2'd1);
        end
        S_DITER: begin
          if (bit_q == '0) val_q <= ugb_val_e'(val_q + 2'd1);
        end
        S_RANGE: begin
          if (func_q == FUNC_QUERY && (sx.wide || sy.wide)) big_q <= 1'b1;
        end
        S_CNT: begin
          found_q <= 1'b0;
          if (func_q == FUNC_INSERT && cnt_cur >= CNT_W'(CELL_CAP)) flag_q <= 1'b1;
        end
        S_ENT: begin
          if (rm_match) found_q <= 1'b1;
          if (func_q == FUNC_QUERY && !stall && keep) begin
            have_q <= 1'b1;
            if (have_q && !need_emit) flag_q <= 1'b1;
            if (need_emit) n_q <= n_q + NB_W'(1);
          end
        end
        default: ;
      endcase

      if (cnt_we) cvalid_q[cell_addr] <= 1'b1;

      if (out_load) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      func_q  <= ugb_func_e'(req_i.func);
      id_q    <= req_i.entity_id;
      min_x_q <= req_i.box_min_x;
      min_y_q <= req_i.box_min_y;
      max_x_q <= req_i.box_max_x;
      max_y_q <= req_i.box_max_y;
    end

    case (state_q)
      S_DLOAD: begin
        rem_q <= {num_src[COORD_W-1], num_src} - {num_org[COORD_W-1], num_org};
      end
      S_DTEST: begin
        dsh_q <= {cs_eff, 5'b00000};
        bit_q <= 3'(QBITS - 1);
        quo_q <= '0;
        if (n_neg) begin
          res_q[val_q] <= '0;
          neg_q[val_q] <= ceil_neg;
        end else if (n_sat) begin
          res_q[val_q] <= {QBITS{1'b1}};
          neg_q[val_q] <= 1'b0;
        end
      end
      S_DITER: begin
        rem_q <= rem_nx;
        dsh_q <= dsh_q >> 1;
        bit_q <= bit_q - 3'd1;
        if (div_ge) quo_q <= quo_nx;
        if (bit_q == '0) begin
          res_q[val_q] <= div_ge ? quo_fin
                                 : ((quo_q == {QBITS{1'b1}} || !is_ceil || rem_nx == '0)
                                    ? quo_q : quo_q + QBITS'(1));
          neg_q[val_q] <= 1'b0;
        end
      end
      S_RANGE: begin
        lox_q <= sx.lo[COL_W-1:0];
        hix_q <= sx.hi[COL_W-1:0];
        hiy_q <= sy.hi[ROW_W-1:0];
        c_q   <= sx.lo[COL_W-1:0];
        r_q   <= sy.lo[ROW_W-1:0];
      end
      S_CNT: begin
        cnt_q <= cnt_cur;
        kd_q  <= '0;
      end
      S_ENT: begin
        // once the cap is hit the held entry stays the final one
        if (func_q == FUNC_QUERY && !stall && keep && (!have_q || need_emit)) begin
          pend_q <= ent_rd_q;
        end
      end
      default: ;
    endcase

    if (adv_slot) kd_q <= kd_q + SLOT_W'(1);

    // row-major advance to the next covered cell
    if (adv_cell && !cell_last) begin
      if (c_q == hix_q) begin
        c_q <= lox_q;
        r_q <= r_q + ROW_W'(1);
      end else begin
        c_q <= c_q + COL_W'(1);
      end
    end

    if (out_load) begin
      out_st_q   <= out_st;
      out_nv_q   <= out_nv;
      out_nid_q  <= out_nid;
      out_last_q <= out_last;
    end
  end

  // ---------------------------------------------------------------- cell count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cell_addr] <= cnt_wdata;
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cell_addr];
      cv_rd_q  <= cvalid_q[cell_addr];
    end
  end

  // ---------------------------------------------------------------- cell entry memory
  logic [ENT_W-1:0] ent_raddr, ent_waddr;
  assign ent_raddr = ENT_W'(cell_addr) * ENT_W'(CELL_CAP) + ENT_W'(ent_rslot);
  assign ent_waddr = ENT_W'(cell_addr) * ENT_W'(CELL_CAP) + ENT_W'(ent_wslot);

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rd_q <= ent_mem[ent_raddr];
  end

endmodule

`default_nettype wire
